[src/nbv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbv_pkg: shared constants and helpers
// Fixed-point constants, item layout and saturation for the N-body step.
// ----------------------------------------------------------------------------
package nbv_pkg;

   localparam int BODIES_DEF = 64;
   localparam int DATA_W     = 320;
   localparam int WORD_W     = 96;
   localparam int MASS_W     = 31;
   localparam int MASS_LSB   = 288;
   localparam int DT_W       = 16;
   localparam logic [DT_W-1:0]   DT_RESET = 16'd1024;
   localparam logic signed [32:0] G_Q16   = 33'sd4374;
   localparam logic [63:0]       EPS2_Q32 = 64'd4295;
   localparam logic [30:0]       F_MAX    = 31'h7FFF_FFFF;
   localparam logic [30:0]       MAG_MAX  = 31'h7FFF_FFFF;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[src/nbody_verlet_step.sv]
`timescale 1ns / 1ps
// Load: one item per cycle while ready. Step: kick and drift per body, force sum per
// ordered body pair (32-step root, 31-step and 3 x 17-step divisions on one shared
// compare-subtract unit, one shared multiplier; the 31-step division is skipped when
// the force term saturates), second kick per body. Output holds each body until taken.
// Not ready for input from the set's last item to its last result.
// Reset (synchronous) clears control, body count and dt (1024); stores are not cleared.
// ----------------------------------------------------------------------------
// nbody_verlet_step: brute-force N-body velocity Verlet step
// Loads bodies, runs kick, drift, all-pairs softened gravity and kick, emits bodies.
// ----------------------------------------------------------------------------
module nbody_verlet_step
   import nbv_pkg::*;
#(
   parameter int MAX_BODIES = BODIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, body_mass, pad
   input  logic [DATA_W-1:0] req_tdata,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // new_pos_x..z, new_vel_x..z, new_acc_x..z, out_mass, pad
   output logic [DATA_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   input  logic              csr_wr_en,
   input  logic [DT_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CNT_W = $clog2(MAX_BODIES + 1);
   localparam int SUM_W = 32 + CNT_W;

   typedef enum logic [27:0] {
      S_LOAD   = 28'b1 << 0,  S_K1_RD  = 28'b1 << 1,  S_K1_MUL = 28'b1 << 2,
      S_K1_ADD = 28'b1 << 3,  S_DR_MUL = 28'b1 << 4,  S_DR_ADD = 28'b1 << 5,
      S_K1_WR  = 28'b1 << 6,  S_ROW_RD = 28'b1 << 7,  S_ROW_LD = 28'b1 << 8,
      S_PR_RD  = 28'b1 << 9,  S_PR_DIF = 28'b1 << 10, S_PR_SQ  = 28'b1 << 11,
      S_PR_ACC = 28'b1 << 12, S_PR_SM  = 28'b1 << 13, S_PR_S   = 28'b1 << 14,
      S_SQRT   = 28'b1 << 15, S_F_CHK  = 28'b1 << 16, S_DIV    = 28'b1 << 17,
      S_U_INIT = 28'b1 << 18, S_U_MUL  = 28'b1 << 19, S_U_ACC  = 28'b1 << 20,
      S_FIN_RD = 28'b1 << 21, S_FIN_MUL = 28'b1 << 22, S_FIN_ADD = 28'b1 << 23,
      S_FIN_WR = 28'b1 << 24, S_OUT_RD = 28'b1 << 25, S_OUT_LD = 28'b1 << 26,
      S_OUT_WAIT = 28'b1 << 27
   } state_type;

   state_type st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, idx_ff, idx_in, jdx_ff, jdx_in;
   logic [1:0]       c_ff, c_in;
   logic [5:0]       step_ff, step_in;
   logic [DT_W-1:0]  dt_ff;
   logic             rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [65:0] prod_ff;
   logic signed [31:0] vw_ff [3], vw_in [3], pw_ff [3], pw_in [3], aw_ff [3], aw_in [3];
   logic signed [SUM_W-1:0] sum_ff [3], sum_in [3];
   logic [30:0] mag_ff [3], mag_in [3];
   logic [2:0]  neg_ff, neg_in;
   logic [WORD_W-1:0] pi_ff, pi_in;
   logic [63:0] d2_ff, d2_in, bit_ff, bit_in;
   logic [28:0] s_ff, s_in;
   logic [31:0] d_ff, d_in;
   logic [30:0] f_ff, f_in, quo_ff, quo_in;
   logic [16:0] u_ff, u_in;
   logic [95:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic        div_f_ff, div_f_in;

   logic [WORD_W-1:0] pos_mem [MAX_BODIES], vel_mem [MAX_BODIES], acc_mem [MAX_BODIES];
   logic [MASS_W-1:0] mass_mem [MAX_BODIES];
   logic [WORD_W-1:0] pos_rd_ff, vel_rd_ff, acc_rd_ff;
   logic [MASS_W-1:0] mass_rd_ff;
   logic              rd_en, pos_we, vel_we, acc_we, mass_we;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [WORD_W-1:0] pos_wd, vel_wd, acc_wd;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p, t17, t16, k17, k16;
   logic [95:0]        sub_a, sub_b;
   logic [96:0]        sub_full;
   logic               ge;
   logic signed [31:0] sel_v, sel_p, sel_a, sel_pi, sum_sat;
   logic signed [63:0] kick_v, drift_p;
   logic signed [32:0] diff;
   logic [32:0]        absd;
   logic [CNT_W-1:0]   idx_inc, jdx_inc, cnt_inc;
   logic [65:0]        s_rnd;
   logic [31:0]        term;

   assign req_tready = (st_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign idx_inc = idx_ff + CNT_W'(1);
   assign jdx_inc = jdx_ff + CNT_W'(1);
   assign cnt_inc = cnt_ff + CNT_W'(1);

   assign sel_v   = $signed(vel_rd_ff[c_ff*32 +: 32]);
   assign sel_p   = $signed(pos_rd_ff[c_ff*32 +: 32]);
   assign sel_a   = $signed(acc_rd_ff[c_ff*32 +: 32]);
   assign sel_pi  = $signed(pi_ff[c_ff*32 +: 32]);
   assign sum_sat = sat32(64'(sum_ff[c_ff]));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (st_ff)
         S_K1_MUL: begin
            mul_a = 33'(sel_a);
            mul_b = {17'b0, dt_ff};
         end
         S_DR_MUL: begin
            mul_a = 33'(vw_ff[c_ff]);
            mul_b = {17'b0, dt_ff};
         end
         S_PR_SQ: begin
            mul_a = {2'b0, mag_ff[c_ff]};
            mul_b = {2'b0, mag_ff[c_ff]};
         end
         S_PR_SM: begin
            mul_a = G_Q16;
            mul_b = {2'b0, mass_rd_ff};
         end
         S_U_MUL: begin
            mul_a = {2'b0, f_ff};
            mul_b = {16'b0, u_ff};
         end
         S_FIN_MUL: begin
            mul_a = 33'(sum_sat);
            mul_b = {17'b0, dt_ff};
         end
         default: begin
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign t17     = prod_ff + 66'sd65536;
   assign t16     = prod_ff + 66'sd32768;
   assign k17     = t17 >>> 17;
   assign k16     = t16 >>> 16;
   assign kick_v  = 64'(st_ff == S_FIN_ADD ? sel_v : sel_v) + $signed(k17[63:0]);
   assign drift_p = 64'(sel_p) + $signed(k16[63:0]);
   assign s_rnd   = prod_ff + 66'sd32768;
   assign term    = prod_ff[47:16];

   assign diff = 33'(sel_p) - 33'(sel_pi);
   assign absd = diff[32] ? 33'(-diff) : diff;

   always_comb begin
      sub_a = rem_ff;
      sub_b = dsh_ff;
      case (st_ff)
         S_SQRT: begin
            sub_b = dsh_ff | {32'b0, bit_ff};
         end
         S_F_CHK: begin
            sub_a = {35'b0, s_ff, 32'b0};
            sub_b = {1'b0, d2_ff, 31'b0};
         end
         default: begin
         end
      endcase
   end
   assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge       = ~sub_full[96];

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      jdx_in = jdx_ff;
      c_in = c_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in = rsp_last_ff;
      rsp_data_in = rsp_data_ff;
      vw_in = vw_ff;
      pw_in = pw_ff;
      aw_in = aw_ff;
      sum_in = sum_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      pi_in = pi_ff;
      d2_in = d2_ff;
      bit_in = bit_ff;
      s_in = s_ff;
      d_in = d_ff;
      f_in = f_ff;
      u_in = u_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      div_f_in = div_f_ff;
      rd_en = 1'b0;
      rd_addr = idx_ff[IDX_W-1:0];
      wr_addr = idx_ff[IDX_W-1:0];
      pos_we = 1'b0;
      vel_we = 1'b0;
      acc_we = 1'b0;
      mass_we = 1'b0;
      pos_wd = {pw_ff[2], pw_ff[1], pw_ff[0]};
      vel_wd = {vw_ff[2], vw_ff[1], vw_ff[0]};
      acc_wd = {aw_ff[2], aw_ff[1], aw_ff[0]};
      case (st_ff)
         S_LOAD: begin
            wr_addr = cnt_ff[IDX_W-1:0];
            pos_wd = req_tdata[95:0];
            vel_wd = req_tdata[191:96];
            acc_wd = req_tdata[287:192];
            if (req_tvalid) begin
               pos_we = 1'b1;
               vel_we = 1'b1;
               acc_we = 1'b1;
               mass_we = 1'b1;
               cnt_in = cnt_inc;
               if (req_tlast || cnt_inc == CNT_W'(MAX_BODIES)) begin
                  idx_in = '0;
                  st_in = S_K1_RD;
               end
            end
         end
         S_K1_RD: begin
            rd_en = 1'b1;
            c_in = '0;
            st_in = S_K1_MUL;
         end
         S_K1_MUL: begin
            st_in = S_K1_ADD;
         end
         S_K1_ADD: begin
            vw_in[c_ff] = sat32(kick_v);
            if (c_ff == 2'd2) begin
               c_in = '0;
               st_in = S_DR_MUL;
            end else begin
               c_in = c_ff + 2'd1;
               st_in = S_K1_MUL;
            end
         end
         S_DR_MUL: begin
            st_in = S_DR_ADD;
         end
         S_DR_ADD: begin
            pw_in[c_ff] = sat32(drift_p);
            if (c_ff == 2'd2) begin
               st_in = S_K1_WR;
            end else begin
               c_in = c_ff + 2'd1;
               st_in = S_DR_MUL;
            end
         end
         S_K1_WR: begin
            pos_we = 1'b1;
            vel_we = 1'b1;
            if (idx_inc == cnt_ff) begin
               idx_in = '0;
               st_in = S_ROW_RD;
            end else begin
               idx_in = idx_inc;
               st_in = S_K1_RD;
            end
         end
         S_ROW_RD: begin
            rd_en = 1'b1;
            st_in = S_ROW_LD;
         end
         S_ROW_LD: begin
            pi_in = pos_rd_ff;
            jdx_in = '0;
            for (int k = 0; k < 3; k++) begin
               sum_in[k] = '0;
            end
            st_in = (mass_rd_ff == '0) ? S_FIN_RD : S_PR_RD;
         end
         S_PR_RD: begin
            rd_addr = jdx_ff[IDX_W-1:0];
            if (jdx_ff == cnt_ff) begin
               st_in = S_FIN_RD;
            end else if (jdx_ff == idx_ff) begin
               jdx_in = jdx_inc;
            end else begin
               rd_en = 1'b1;
               c_in = '0;
               st_in = S_PR_DIF;
            end
         end
         S_PR_DIF: begin
            neg_in[c_ff] = diff[32];
            mag_in[c_ff] = (absd > {2'b0, MAG_MAX}) ? MAG_MAX : absd[30:0];
            d2_in = EPS2_Q32;
            if (c_ff == 2'd2) begin
               c_in = '0;
               st_in = S_PR_SQ;
            end else begin
               c_in = c_ff + 2'd1;
            end
         end
         S_PR_SQ: begin
            st_in = S_PR_ACC;
         end
         S_PR_ACC: begin
            d2_in = d2_ff + prod_ff[63:0];
            if (c_ff == 2'd2) begin
               st_in = S_PR_SM;
            end else begin
               c_in = c_ff + 2'd1;
               st_in = S_PR_SQ;
            end
         end
         S_PR_SM: begin
            st_in = S_PR_S;
         end
         S_PR_S: begin
            s_in = s_rnd[44:16];
            rem_in = {32'b0, d2_ff};
            dsh_in = '0;
            bit_in = 64'h4000_0000_0000_0000;
            step_in = 6'd31;
            st_in = S_SQRT;
         end
         S_SQRT: begin
            if (ge) begin
               rem_in = sub_full[95:0];
               dsh_in = (dsh_ff >> 1) | {32'b0, bit_ff};
            end else begin
               dsh_in = dsh_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            step_in = step_ff - 6'd1;
            if (step_ff == '0) begin
               st_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            d_in = dsh_ff[31:0];
            if (ge) begin
               f_in = F_MAX;
               c_in = '0;
               st_in = S_U_INIT;
            end else begin
               rem_in = {35'b0, s_ff, 32'b0};
               dsh_in = {2'b0, d2_ff, 30'b0};
               quo_in = '0;
               step_in = 6'd30;
               div_f_in = 1'b1;
               st_in = S_DIV;
            end
         end
         S_DIV: begin
            if (ge) begin
               rem_in = sub_full[95:0];
            end
            quo_in = {quo_ff[29:0], ge};
            dsh_in = dsh_ff >> 1;
            step_in = step_ff - 6'd1;
            if (step_ff == '0) begin
               if (div_f_ff) begin
                  f_in = {quo_ff[29:0], ge};
                  c_in = '0;
                  st_in = S_U_INIT;
               end else begin
                  u_in = {quo_ff[15:0], ge};
                  st_in = S_U_MUL;
               end
            end
         end
         S_U_INIT: begin
            rem_in = {49'b0, mag_ff[c_ff], 16'b0};
            dsh_in = {48'b0, d_ff, 16'b0};
            quo_in = '0;
            step_in = 6'd16;
            div_f_in = 1'b0;
            st_in = S_DIV;
         end
         S_U_MUL: begin
            st_in = S_U_ACC;
         end
         S_U_ACC: begin
            sum_in[c_ff] = neg_ff[c_ff] ? sum_ff[c_ff] - SUM_W'(term)
                                        : sum_ff[c_ff] + SUM_W'(term);
            if (c_ff == 2'd2) begin
               jdx_in = jdx_inc;
               st_in = S_PR_RD;
            end else begin
               c_in = c_ff + 2'd1;
               st_in = S_U_INIT;
            end
         end
         S_FIN_RD: begin
            rd_en = 1'b1;
            c_in = '0;
            st_in = S_FIN_MUL;
         end
         S_FIN_MUL: begin
            st_in = S_FIN_ADD;
         end
         S_FIN_ADD: begin
            vw_in[c_ff] = sat32(kick_v);
            aw_in[c_ff] = sum_sat;
            if (c_ff == 2'd2) begin
               st_in = S_FIN_WR;
            end else begin
               c_in = c_ff + 2'd1;
               st_in = S_FIN_MUL;
            end
         end
         S_FIN_WR: begin
            vel_we = 1'b1;
            acc_we = 1'b1;
            if (idx_inc == cnt_ff) begin
               idx_in = '0;
               st_in = S_OUT_RD;
            end else begin
               idx_in = idx_inc;
               st_in = S_ROW_RD;
            end
         end
         S_OUT_RD: begin
            rd_en = 1'b1;
            st_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_data_in = {1'b0, mass_rd_ff, acc_rd_ff, vel_rd_ff, pos_rd_ff};
            rsp_last_in = (idx_inc == cnt_ff);
            rsp_valid_in = 1'b1;
            st_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  cnt_in = '0;
                  st_in = S_LOAD;
               end else begin
                  idx_in = idx_inc;
                  st_in = S_OUT_RD;
               end
            end
         end
         default: begin
            st_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD;
         cnt_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         dt_ff <= DT_RESET;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            dt_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      jdx_ff <= jdx_in;
      c_ff <= c_in;
      step_ff <= step_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
      vw_ff <= vw_in;
      pw_ff <= pw_in;
      aw_ff <= aw_in;
      sum_ff <= sum_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      pi_ff <= pi_in;
      d2_ff <= d2_in;
      bit_ff <= bit_in;
      s_ff <= s_in;
      d_ff <= d_in;
      f_ff <= f_in;
      u_ff <= u_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      div_f_ff <= div_f_in;
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[wr_addr] <= pos_wd;
      end
      if (vel_we) begin
         vel_mem[wr_addr] <= vel_wd;
      end
      if (acc_we) begin
         acc_mem[wr_addr] <= acc_wd;
      end
      if (mass_we) begin
         mass_mem[wr_addr] <= req_tdata[MASS_LSB +: MASS_W];
      end
      if (rd_en) begin
         pos_rd_ff <= pos_mem[rd_addr];
         vel_rd_ff <= vel_mem[rd_addr];
         acc_rd_ff <= acc_mem[rd_addr];
         mass_rd_ff <= mass_mem[rd_addr];
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while an item is pending");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BODIES))
      else $error("body count beyond store depth");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (idx_inc == cnt_ff))
      else $error("last flag on wrong body");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && cnt_ff == '0))
      else $error("no return to load after final item");
`endif

endmodule
